[rtl/clt_pkg.sv]
// clt_pkg: shared constants, status codes and the result word type of the
// command line tokenizer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package clt_pkg;

   // default sizing of the tokenizer
   localparam int DEF_MAX_COMMANDS  = 8;
   localparam int DEF_COMMAND_BYTES = 64;
   localparam int DEF_MAX_ARGS      = 9;

   // special bytes
   localparam logic [7:0] SPACE_BYTE = 8'd32;
   localparam logic [7:0] PIPE_BYTE  = 8'd124;
   localparam logic [7:0] QUOTE_BYTE = 8'd34;

   // line status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_MANY = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   // saturation limits of the reported counters
   localparam logic [2:0] CMD_NUM_MAX = 3'd7;
   localparam logic [3:0] ARG_NUM_MAX = 4'd15;
   localparam logic [3:0] CMD_CNT_MAX = 4'd15;

   // one result word
   typedef struct packed {
      logic       keep_byte;
      logic [7:0] arg_byte;
      logic       arg_opens;
      logic       arg_closes;
      logic       command_ends;
      logic [2:0] command_number;
      logic [3:0] arg_number;
      logic [1:0] line_status;
      logic       line_done;
   } result_type;

endpackage

`default_nettype wire

[rtl/clt_scan.sv]
// clt_scan: per-line scan state of the tokenizer and the combinational
// result of one byte; depends on clt_pkg
`timescale 1ns / 1ps
`default_nettype none

module clt_scan #(
   parameter int MAX_COMMANDS  = clt_pkg::DEF_MAX_COMMANDS,
   parameter int COMMAND_BYTES = clt_pkg::DEF_COMMAND_BYTES,
   parameter int MAX_ARGS      = clt_pkg::DEF_MAX_ARGS
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 step,
   input  wire [7:0]           line_byte,
   input  wire                 line_last,
   output clt_pkg::result_type result
);
   import clt_pkg::*;

   localparam int AW = $clog2(MAX_ARGS + 1);
   localparam int LW = (COMMAND_BYTES > 2) ? $clog2(COMMAND_BYTES) : 1;
   localparam logic [3:0]    CMD_LIMIT = 4'(MAX_COMMANDS - 1);
   localparam logic [AW-1:0] ARG_LIMIT = AW'(MAX_ARGS);
   localparam logic [LW-1:0] LEN_LIMIT = LW'(COMMAND_BYTES - 1);

   typedef enum logic [2:0] {
      MODE_SKIP,
      MODE_PLAIN,
      MODE_QSTART,
      MODE_QUOTE,
      MODE_IGNORE
   } mode_type;

   mode_type        mode_ff, mode_in;
   logic [3:0]      cmd_cnt_ff, cmd_cnt_in;
   logic [AW-1:0]   arg_cnt_ff, arg_cnt_in;
   logic [LW-1:0]   len_ff, len_in;
   logic [1:0]      err_ff, err_in;
   logic            started_ff, started_in;

   logic            is_pipe, is_space, is_quote, was_open, now_open;
   logic            keep, opens, closes, cend;
   logic [3:0]      cn;
   logic [AW-1:0]   an;
   logic [4:0]      an_wide;

   assign is_pipe  = (line_byte == PIPE_BYTE);
   assign is_space = (line_byte == SPACE_BYTE);
   assign is_quote = (line_byte == QUOTE_BYTE);
   assign was_open = (mode_ff == MODE_PLAIN) || (mode_ff == MODE_QSTART) ||
                     (mode_ff == MODE_QUOTE);
   assign now_open = (mode_in == MODE_PLAIN) || (mode_in == MODE_QSTART) ||
                     (mode_in == MODE_QUOTE);

   always_comb begin
      mode_in    = mode_ff;
      cmd_cnt_in = cmd_cnt_ff;
      arg_cnt_in = arg_cnt_ff;
      len_in     = len_ff;
      err_in     = err_ff;
      started_in = started_ff;
      keep       = 1'b0;
      opens      = 1'b0;
      closes     = 1'b0;
      cend       = 1'b0;
      if (is_pipe) begin
         // pipe ends the command, quoted or not
         cend   = 1'b1;
         closes = was_open;
         if (cmd_cnt_ff >= CMD_LIMIT) begin
            err_in = STATUS_TOO_MANY;
         end
         if (cmd_cnt_ff < CMD_CNT_MAX) begin
            cmd_cnt_in = cmd_cnt_ff + 4'd1;
         end
         mode_in    = MODE_SKIP;
         arg_cnt_in = '0;
         len_in     = '0;
         started_in = 1'b0;
      end else begin
         if (started_ff || !is_space) begin
            started_in = 1'b1;
            if (len_ff >= LEN_LIMIT) begin
               if (err_ff == STATUS_OK) begin
                  err_in = STATUS_TOO_LONG;
               end
            end else begin
               len_in = len_ff + LW'(1);
            end
         end
         case (mode_ff)
            MODE_SKIP: begin
               if (!is_space) begin
                  if (arg_cnt_ff >= ARG_LIMIT) begin
                     mode_in = MODE_IGNORE;
                  end else begin
                     arg_cnt_in = arg_cnt_ff + AW'(1);
                     opens      = 1'b1;
                     if (is_quote) begin
                        mode_in = MODE_QSTART;
                     end else begin
                        keep    = 1'b1;
                        mode_in = MODE_PLAIN;
                     end
                  end
               end
            end
            MODE_PLAIN: begin
               if (is_space) begin
                  closes  = 1'b1;
                  mode_in = MODE_SKIP;
               end else begin
                  keep = 1'b1;
                  if (is_quote) begin
                     mode_in = MODE_QUOTE;
                  end
               end
            end
            MODE_QSTART: begin
               keep    = 1'b1;
               mode_in = MODE_QUOTE;
            end
            MODE_QUOTE: begin
               if (is_quote) begin
                  closes  = 1'b1;
                  mode_in = MODE_SKIP;
               end else begin
                  keep = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_IGNORE;
            end
         endcase
         if (line_last) begin
            closes = closes | now_open;
            cend   = 1'b1;
         end
      end
   end

   // pipe reports the counts from before it, content the updated ones
   assign cn      = is_pipe ? cmd_cnt_ff : cmd_cnt_in;
   assign an      = is_pipe ? arg_cnt_ff : arg_cnt_in;
   assign an_wide = 5'(an);

   always_comb begin
      result.keep_byte      = keep;
      result.arg_byte       = keep ? line_byte : 8'd0;
      result.arg_opens      = opens;
      result.arg_closes     = closes;
      result.command_ends   = cend;
      result.command_number = (cn > 4'(CMD_NUM_MAX)) ? CMD_NUM_MAX : cn[2:0];
      result.arg_number     = (an_wide > 5'(ARG_NUM_MAX)) ? ARG_NUM_MAX : an_wide[3:0];
      result.line_status    = err_in;
      result.line_done      = line_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_SKIP;
         cmd_cnt_ff <= '0;
         arg_cnt_ff <= '0;
         len_ff     <= '0;
         err_ff     <= STATUS_OK;
         started_ff <= 1'b0;
      end else if (step) begin
         if (line_last) begin
            mode_ff    <= MODE_SKIP;
            cmd_cnt_ff <= '0;
            arg_cnt_ff <= '0;
            len_ff     <= '0;
            err_ff     <= STATUS_OK;
            started_ff <= 1'b0;
         end else begin
            mode_ff    <= mode_in;
            cmd_cnt_ff <= cmd_cnt_in;
            arg_cnt_ff <= arg_cnt_in;
            len_ff     <= len_in;
            err_ff     <= err_in;
            started_ff <= started_in;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/command_line_tokenizer_unit.sv]
// command_line_tokenizer_unit: top level of the command line tokenizer,
// input word register, scan state (clt_scan) and result register; uses clt_pkg
//
//   channel | dir | ports                      | carries
//   --------+-----+----------------------------+------------------------------
//   req     | in  | tvalid tready tdata tlast  | one line byte, tlast = last byte
//   rsp     | out | tvalid tready tdata tuser  | one result word per byte,
//           |     | tlast                      | tlast = line done
//
// one word per cycle sustained while rsp takes words; a byte goes from req to rsp
// through the input register, then scan logic into the result register
// the scan state advances when a word moves from the input register into
// the result register, so the byte order is kept under any stall pattern
// reset is synchronous and active high; it clears the valid flags and
// the scan state, payload registers are not reset
// a stalled rsp holds its word; req keeps taking words until both
// registers are full
`timescale 1ns / 1ps
`default_nettype none

module command_line_tokenizer_unit #(
   parameter int MAX_COMMANDS  = clt_pkg::DEF_MAX_COMMANDS,
   parameter int COMMAND_BYTES = clt_pkg::DEF_COMMAND_BYTES,
   parameter int MAX_ARGS      = clt_pkg::DEF_MAX_ARGS
) (
   input  wire         clock,
   input  wire         reset,
   // input byte stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] line_byte
   input  wire         req_tlast,   // line_last
   // result stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] arg_byte, [10:8] command_number,
                                    // [14:11] arg_number, [16:15] line_status,
                                    // [23:17] zero
   output logic [3:0]  rsp_tuser,   // [0] keep_byte, [1] arg_opens,
                                    // [2] arg_closes, [3] command_ends
   output logic        rsp_tlast    // line_done
);
   import clt_pkg::*;

   // input word register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   // result register
   logic        out_valid_ff;
   result_type  out_ff;

   result_type  scan_result;
   logic        step;

   // a word moves forward when the result slot is free or being emptied
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   clt_scan #(
      .MAX_COMMANDS  (MAX_COMMANDS),
      .COMMAND_BYTES (COMMAND_BYTES),
      .MAX_ARGS      (MAX_ARGS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .line_byte (in_byte_ff),
      .line_last (in_last_ff),
      .result    (scan_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= scan_result;
      end
   end

   // pack the result word
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff.line_status, out_ff.arg_number,
                        out_ff.command_number, out_ff.arg_byte};
   assign rsp_tuser  = {out_ff.command_ends, out_ff.arg_closes,
                        out_ff.arg_opens, out_ff.keep_byte};
   assign rsp_tlast  = out_ff.line_done;

   // a byte that is not kept reports zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[7:0] == 8'd0)
      else $error("dropped byte carries data");

   // the line end always ends the command
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[3])
      else $error("line end without command end");

   // input only stalls when both registers are full and rsp is blocked
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("input stalled without backpressure");

   // status never takes the unused code
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16:15] != 2'd3)
      else $error("bad line status code");

endmodule

`default_nettype wire

[test/clt_result_checker.sv]
// clt_result_checker: watches the byte and result streams of the command line
// tokenizer, predicts every result word and compares it field by field; uses clt_pkg
`timescale 1ns / 1ps

module clt_result_checker #(
   parameter int MAX_COMMANDS  = clt_pkg::DEF_MAX_COMMANDS,
   parameter int COMMAND_BYTES = clt_pkg::DEF_COMMAND_BYTES,
   parameter int MAX_ARGS      = clt_pkg::DEF_MAX_ARGS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [3:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          results_pending
);
   import clt_pkg::*;

   typedef enum logic [2:0] {
      SCAN_SKIP,
      SCAN_PLAIN,
      SCAN_QSTART,
      SCAN_QUOTE,
      SCAN_IGNORE
   } scan_mode_type;

   // tokenizer state
   scan_mode_type                  scan_mode;
   logic [3:0]                     cmd_count;
   logic [3:0]                     arg_count;
   logic [$clog2(COMMAND_BYTES):0] cmd_length;
   logic [1:0]                     line_error;
   logic                           cmd_started;

   result_type predicted_results[$];

   function automatic bit arg_in_progress(input scan_mode_type mode);
      return mode == SCAN_PLAIN || mode == SCAN_QSTART || mode == SCAN_QUOTE;
   endfunction

   task automatic start_command();
      scan_mode   = SCAN_SKIP;
      arg_count   = '0;
      cmd_length  = '0;
      cmd_started = 1'b0;
   endtask

   task automatic clear_line();
      start_command();
      cmd_count  = '0;
      line_error = STATUS_OK;
   endtask

   // one line byte in, one result word out
   task automatic tokenize_byte(input logic [7:0] line_byte, input logic line_last,
                                output result_type word);
      word = '0;
      word.line_done = line_last;
      if (line_byte == PIPE_BYTE) begin
         word.command_ends = 1'b1;
         word.arg_closes   = arg_in_progress(scan_mode);
         if (cmd_count >= MAX_COMMANDS - 1) begin
            line_error = STATUS_TOO_MANY;
         end
         word.command_number = (cmd_count > CMD_NUM_MAX) ? CMD_NUM_MAX : cmd_count[2:0];
         word.arg_number     = arg_count;
         if (cmd_count != CMD_CNT_MAX) begin
            cmd_count++;
         end
         start_command();
      end else begin
         // leading spaces do not count toward the command length
         if (cmd_started || line_byte != SPACE_BYTE) begin
            cmd_started = 1'b1;
            if (cmd_length >= COMMAND_BYTES - 1) begin
               if (line_error == STATUS_OK) begin
                  line_error = STATUS_TOO_LONG;
               end
            end else begin
               cmd_length++;
            end
         end
         case (scan_mode)
            SCAN_SKIP: begin
               if (line_byte != SPACE_BYTE) begin
                  if (arg_count >= MAX_ARGS) begin
                     scan_mode = SCAN_IGNORE;
                  end else begin
                     arg_count++;
                     word.arg_opens = 1'b1;
                     if (line_byte == QUOTE_BYTE) begin
                        scan_mode = SCAN_QSTART;
                     end else begin
                        word.keep_byte = 1'b1;
                        scan_mode      = SCAN_PLAIN;
                     end
                  end
               end
            end
            SCAN_PLAIN: begin
               if (line_byte == SPACE_BYTE) begin
                  word.arg_closes = 1'b1;
                  scan_mode       = SCAN_SKIP;
               end else begin
                  word.keep_byte = 1'b1;
                  if (line_byte == QUOTE_BYTE) begin
                     scan_mode = SCAN_QUOTE;
                  end
               end
            end
            SCAN_QSTART: begin
               word.keep_byte = 1'b1;
               scan_mode      = SCAN_QUOTE;
            end
            SCAN_QUOTE: begin
               if (line_byte == QUOTE_BYTE) begin
                  word.arg_closes = 1'b1;
                  scan_mode       = SCAN_SKIP;
               end else begin
                  word.keep_byte = 1'b1;
               end
            end
            default: begin
               scan_mode = SCAN_IGNORE;
            end
         endcase
         if (line_last) begin
            if (arg_in_progress(scan_mode)) begin
               word.arg_closes = 1'b1;
            end
            word.command_ends = 1'b1;
         end
         word.command_number = (cmd_count > CMD_NUM_MAX) ? CMD_NUM_MAX : cmd_count[2:0];
         word.arg_number     = arg_count;
      end
      word.arg_byte    = word.keep_byte ? line_byte : 8'd0;
      word.line_status = line_error;
      if (line_last) begin
         clear_line();
      end
   endtask

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         clear_line();
         predicted_results.delete();
      end else begin
         // the result side first, so a word can never meet its own prediction
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_results.size() == 0) begin
               $error("result word with no line byte outstanding");
               mismatches++;
            end else begin
               want = predicted_results.pop_front();
               compare_field("keep_byte", want.keep_byte, rsp_tuser[0]);
               compare_field("arg_byte", want.arg_byte, rsp_tdata[7:0]);
               compare_field("arg_opens", want.arg_opens, rsp_tuser[1]);
               compare_field("arg_closes", want.arg_closes, rsp_tuser[2]);
               compare_field("command_ends", want.command_ends, rsp_tuser[3]);
               compare_field("command_number", want.command_number, rsp_tdata[10:8]);
               compare_field("arg_number", want.arg_number, rsp_tdata[14:11]);
               compare_field("line_status", want.line_status, rsp_tdata[16:15]);
               compare_field("line_done", want.line_done, rsp_tlast);
               compare_field("tdata padding", 0, rsp_tdata[23:17]);
            end
         end
         if (req_tvalid && req_tready) begin
            tokenize_byte(req_tdata, req_tlast, want);
            predicted_results.push_back(want);
         end
      end
      results_pending = predicted_results.size();
   end

endmodule

[test/command_line_tokenizer_unit_tb.sv]
// command_line_tokenizer_unit_tb: stimulus and verdict for the command line
// tokenizer; depends on clt_pkg, command_line_tokenizer_unit and clt_result_checker
`timescale 1ns / 1ps

module command_line_tokenizer_unit_tb;
   import clt_pkg::*;

   // size of the random part, in line bytes
   localparam int RANDOM_BYTES     = 1850;
   // receiver hold-off long enough to back the block up into its input
   localparam int LONG_HOLD_CYCLES = 60;
   // cycles allowed after the last result for stray words to show up
   localparam int SETTLE_CYCLES    = 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;

   int mismatches;
   int results_pending;

   // idling knobs: off gives stretches of back to back words
   bit req_idle_on   = 1'b1;
   bit rsp_idle_on   = 1'b1;
   // one-shot request for a long receiver hold-off
   bit hold_results  = 1'b0;
   int bytes_sent    = 0;

   // bytes of the line under construction
   logic [7:0] line_text[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   command_line_tokenizer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   clt_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatches      (mismatches),
      .results_pending (results_pending)
   );

   // any byte that is not one of the three special ones
   function automatic logic [7:0] plain_byte();
      logic [7:0] pick;
      do begin
         pick = 8'($urandom_range(0, 255));
      end while (pick == SPACE_BYTE || pick == PIPE_BYTE || pick == QUOTE_BYTE);
      return pick;
   endfunction

   // content between quotes: mostly plain, some spaces, now and then a pipe
   // (which still splits the command)
   function automatic logic [7:0] quoted_byte();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick < 3) begin
         return SPACE_BYTE;
      end else if (pick == 3) begin
         return PIPE_BYTE;
      end
      return plain_byte();
   endfunction

   // called right after a rising edge; returns right after the edge that took the word
   task automatic send_byte(input logic [7:0] line_byte, input logic line_last);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= line_byte;
      req_tlast  <= line_last;
      // ready is stable between edges, so look at it mid-cycle
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_line();
      foreach (line_text[i]) begin
         send_byte(line_text[i], i == line_text.size() - 1);
      end
   endtask

   // sender stops offering until every predicted word has come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (results_pending != 0);
      @(posedge clock);
   endtask

   // one command: leading spaces, then arguments of mixed quoting styles
   task automatic build_command(input bit overlong, input bit many_args, input bit terse);
      int n_args;
      int len;
      int kind;
      bit after_quote;
      repeat ($urandom_range(0, 3)) line_text.push_back(SPACE_BYTE);
      if (many_args) begin
         n_args = $urandom_range(8, 12);  // can run past the argument limit
      end else if (terse) begin
         n_args = $urandom_range(0, 2);
      end else begin
         n_args = $urandom_range(0, 4);
      end
      after_quote = 1'b0;
      for (int a = 0; a < n_args; a++) begin
         // a closing quote needs no space before the next argument
         if (a > 0) begin
            repeat ($urandom_range(after_quote ? 0 : 1, 2)) line_text.push_back(SPACE_BYTE);
         end
         len  = (overlong && a == 0) ? $urandom_range(58, 72) : $urandom_range(1, 6);
         kind = $urandom_range(0, 4);
         after_quote = (kind >= 3);
         if (kind < 3) begin
            repeat (len) line_text.push_back(plain_byte());
         end else if (kind == 3) begin
            // opening quote; the byte after it is kept whatever it is
            line_text.push_back(QUOTE_BYTE);
            if ($urandom_range(0, 3) == 0) begin
               line_text.push_back($urandom_range(0, 1) ? QUOTE_BYTE : SPACE_BYTE);
            end
            repeat (len) line_text.push_back(quoted_byte());
            if ($urandom_range(0, 7) != 0) begin
               line_text.push_back(QUOTE_BYTE);
            end
         end else begin
            // quote in the middle of a word is kept and starts quote mode
            line_text.push_back(plain_byte());
            line_text.push_back(QUOTE_BYTE);
            repeat (len) line_text.push_back(quoted_byte());
            line_text.push_back(QUOTE_BYTE);
         end
      end
      repeat ($urandom_range(0, 1)) line_text.push_back(SPACE_BYTE);
   endtask

   // mostly well-formed pipelines, the rest byte noise heavy in special bytes
   task automatic build_line();
      int n_cmds;
      int pick;
      bit crowded;
      bit overlong;
      line_text.delete();
      if ($urandom_range(0, 9) < 2) begin
         repeat ($urandom_range(1, 16)) begin
            pick = $urandom_range(0, 7);
            if (pick < 2) begin
               line_text.push_back(SPACE_BYTE);
            end else if (pick == 2) begin
               line_text.push_back(PIPE_BYTE);
            end else if (pick == 3) begin
               line_text.push_back(QUOTE_BYTE);
            end else begin
               line_text.push_back(8'($urandom_range(0, 255)));
            end
         end
      end else begin
         crowded  = ($urandom_range(0, 11) == 0);  // can give enough pipes for too-many
         overlong = ($urandom_range(0, 9) == 0);   // one command past the length limit
         n_cmds   = crowded ? $urandom_range(7, 10) : $urandom_range(1, 3);
         for (int c = 0; c < n_cmds; c++) begin
            if (c > 0) begin
               line_text.push_back(PIPE_BYTE);
            end
            build_command(overlong && c == n_cmds - 1,
                          !crowded && $urandom_range(0, 5) == 0, crowded);
         end
      end
      if (line_text.size() == 0) begin
         line_text.push_back(plain_byte());
      end
   endtask

   // result side: random stalls per word, plus the long hold-off on request
   initial begin : result_sink
      int stall;
      int words_taken;
      words_taken = 0;
      do @(negedge clock); while (reset);
      @(posedge clock);
      forever begin
         if (words_taken % 50 == 0) begin
            rsp_idle_on = ($urandom_range(0, 2) != 0);
         end
         stall = rsp_idle_on ? $urandom_range(0, 9) : 0;
         if (hold_results) begin
            stall        = LONG_HOLD_CYCLES;
            hold_results = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         @(posedge clock);
         words_taken++;
      end
   end

   // stimulus and verdict
   initial begin : line_source
      int directed_bytes;
      int line_index;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed lines
      // zero byte opens, mid-word quote, empty quoted span, spaces kept in quotes,
      // word right after a closing quote, pipe, 0xff, quote as the final byte
      line_text = '{8'h00, QUOTE_BYTE, QUOTE_BYTE, SPACE_BYTE, "x", QUOTE_BYTE, SPACE_BYTE,
                    QUOTE_BYTE, "y", SPACE_BYTE, PIPE_BYTE, 8'hFF, QUOTE_BYTE};
      send_line();
      // leading spaces, opening quote followed by a quote, pipe as the final byte
      line_text = '{SPACE_BYTE, SPACE_BYTE, QUOTE_BYTE, QUOTE_BYTE, SPACE_BYTE, QUOTE_BYTE,
                    PIPE_BYTE};
      send_line();
      // pipe inside quotes still splits, space as the final byte
      line_text = '{QUOTE_BYTE, "a", PIPE_BYTE, "b", SPACE_BYTE};
      send_line();
      // line of a single space
      line_text = '{SPACE_BYTE};
      send_line();
      wait_results_drained();
      directed_bytes = bytes_sent;

      // random lines
      line_index = 0;
      while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
         build_line();
         req_idle_on = ($urandom_range(0, 3) != 0);
         // back the block up: receiver holds off while bytes keep coming
         if (line_index == 2 || line_index == 30) begin
            hold_results = 1'b1;
            req_idle_on  = 1'b0;
         end
         send_line();
         line_index++;
         if (line_index % 8 == 0) begin
            wait_results_drained();
         end
      end

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && results_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
